/* hw/rtl/ipv4lpm_pkg.sv */
// Shared types, codes and helpers for the IPv4 longest-prefix-match table.
package ipv4lpm_pkg;

  localparam int unsigned DefaultDepth = 32;
  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW = 6;
  localparam logic [LenW-1:0] MaxLen = LenW'(32);
  localparam logic [AddrW-1:0] AllOnes = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DEL    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEN   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // What the traveling token is doing as it reaches a cell.
  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_SHIFT  = 2'd1,
    MODE_PULL   = 2'd2,
    MODE_DONE   = 2'd3
  } mode_e;

  // Operation broadcast to every cell while the token runs.
  typedef struct packed {
    action_e           op;
    logic [AddrW-1:0]  addr;
    logic [LenW-1:0]   len;
    logic              full;
  } cmd_t;

  // Token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic              active;
    mode_e             mode;
    logic [AddrW-1:0]  carry_base;
    logic [LenW-1:0]   carry_len;
    status_e           status;
    logic              matched;
    logic [LenW-1:0]   mlen;
    logic              inc;
    logic              dec;
  } token_t;

  // Network mask for a prefix length of 0..32; length 0 covers everything.
  function automatic logic [AddrW-1:0] len_mask(logic [LenW-1:0] len);
    return ~(AllOnes >> len);
  endfunction

endpackage

/* hw/rtl/ipv4_prefix_table_lpm.sv */
// Top level: IPv4 prefix table kept sorted by length, with add, delete and lookup.
//
//   channel | signals                               | word
//   --------+---------------------------------------+------------------------------
//   in      | in_valid_i / in_ready_o               | action, address, prefix_len
//   out     | out_valid_o / out_ready_i             | status, matched, match_len
//
// Each word sends a token down the row of TABLE_DEPTH cells, one cell per cycle;
// its result word is registered from the token that leaves the last cell, and the
// next word can be taken once that token has left the row.
// One word is in the row at a time; a new word is taken as soon as the row is
// free and the one-deep result buffer behind the output register is empty.
// Reset clears the entry count and all handshake state; no clearing pass.
// A stalled output holds its word; the next result waits in the buffer.
module ipv4_prefix_table_lpm #(
  parameter int unsigned TABLE_DEPTH = ipv4lpm_pkg::DefaultDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  input  logic [ipv4lpm_pkg::AddrW-1:0]   address_i,
  input  logic [ipv4lpm_pkg::LenW-1:0]    prefix_len_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic                            matched_o,
  output logic [ipv4lpm_pkg::LenW-1:0]    match_len_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    ipv4lpm_pkg::status_e          status;
    logic                          matched;
    logic [ipv4lpm_pkg::LenW-1:0]  mlen;
  } result_t;

  logic [CntW-1:0]         count_q, count_d;
  logic                    running_q;
  ipv4lpm_pkg::cmd_t       cmd_q;
  ipv4lpm_pkg::token_t     start_q, start_d;
  result_t                 out_q, pend_q, fin;
  logic                    out_valid_q, pend_valid_q;
  logic                    accept, finish, out_free;
  ipv4lpm_pkg::action_e    act;

  ipv4lpm_pkg::token_t                tok   [TABLE_DEPTH+1];
  logic [ipv4lpm_pkg::AddrW-1:0]      bases [TABLE_DEPTH];
  logic [ipv4lpm_pkg::LenW-1:0]       lens  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]             slot_valid;

  assign act        = ipv4lpm_pkg::action_e'(action_i);
  assign in_ready_o = !running_q && !pend_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = tok[TABLE_DEPTH].active;
  assign out_free   = !out_valid_q || out_ready_i;

  // start token: bad lengths and the unused code finish before the first cell
  always_comb begin
    start_d        = '0;
    start_d.active = accept;
    start_d.mode   = ipv4lpm_pkg::MODE_SEARCH;
    start_d.status = ipv4lpm_pkg::ST_OK;
    if ((act == ipv4lpm_pkg::ACT_ADD) || (act == ipv4lpm_pkg::ACT_DEL)) begin
      if (prefix_len_i > ipv4lpm_pkg::MaxLen) begin
        start_d.mode   = ipv4lpm_pkg::MODE_DONE;
        start_d.status = ipv4lpm_pkg::ST_BAD_LEN;
      end
    end else if (act == ipv4lpm_pkg::ACT_NONE) begin
      start_d.mode = ipv4lpm_pkg::MODE_DONE;
    end
  end

  assign tok[0] = start_q;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [ipv4lpm_pkg::AddrW-1:0] nb_base;
    logic [ipv4lpm_pkg::LenW-1:0]  nb_len;

    assign slot_valid[i] = count_q > CntW'(i);

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nb_base = bases[i];
      assign nb_len  = lens[i];
    end else begin : g_mid
      assign nb_base = bases[i+1];
      assign nb_len  = lens[i+1];
    end

    ipv4lpm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (slot_valid[i]),
      .cmd_i    (cmd_q),
      .tok_i    (tok[i]),
      .nb_base_i(nb_base),
      .nb_len_i (nb_len),
      .tok_o    (tok[i+1]),
      .base_o   (bases[i]),
      .len_o    (lens[i])
    );
  end

  // a token still searching at the end of the row saw a full table (add) or no entry (delete)
  always_comb begin
    fin.status  = tok[TABLE_DEPTH].status;
    fin.matched = tok[TABLE_DEPTH].matched;
    fin.mlen    = tok[TABLE_DEPTH].mlen;
    if (tok[TABLE_DEPTH].mode == ipv4lpm_pkg::MODE_SEARCH) begin
      case (cmd_q.op)
        ipv4lpm_pkg::ACT_ADD: fin.status = ipv4lpm_pkg::ST_FULL;
        ipv4lpm_pkg::ACT_DEL: fin.status = ipv4lpm_pkg::ST_NOT_FOUND;
        default:              ;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (finish) begin
      count_d = count_q + CntW'(tok[TABLE_DEPTH].inc) - CntW'(tok[TABLE_DEPTH].dec);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      running_q    <= 1'b0;
      start_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      start_q <= start_d;
      if (accept) begin
        running_q <= 1'b1;
      end else if (finish) begin
        running_q <= 1'b0;
      end
      if (finish) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          pend_valid_q <= 1'b1;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q  <= pend_valid_q;
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op   <= act;
      cmd_q.addr <= address_i;
      cmd_q.len  <= prefix_len_i;
      cmd_q.full <= count_q == CntW'(TABLE_DEPTH);
    end
    if (finish) begin
      if (out_free) begin
        out_q <= fin;
      end else begin
        pend_q <= fin;
      end
    end else if (out_valid_q && out_ready_i && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign matched_o   = out_q.matched;
  assign match_len_o = out_q.mlen;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finish |=> $stable(count_q))
    else $error("entry count moved with no token at the end of the row");

  a_finish_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> running_q)
    else $error("token left the row with no word in flight");

  a_pend_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("buffered result without an output word ahead of it");

  a_match_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && matched_o |-> (status_o == ipv4lpm_pkg::ST_OK))
    else $error("match flagged on a result with error status");

endmodule

/* hw/rtl/ipv4lpm_cell.sv */
// One table slot: holds a prefix and acts on the token as it passes.
module ipv4lpm_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  ipv4lpm_pkg::cmd_t               cmd_i,
  input  ipv4lpm_pkg::token_t             tok_i,
  input  logic [ipv4lpm_pkg::AddrW-1:0]   nb_base_i,
  input  logic [ipv4lpm_pkg::LenW-1:0]    nb_len_i,
  output ipv4lpm_pkg::token_t             tok_o,
  output logic [ipv4lpm_pkg::AddrW-1:0]   base_o,
  output logic [ipv4lpm_pkg::LenW-1:0]    len_o
);

  logic [ipv4lpm_pkg::AddrW-1:0] base_q, base_d;
  logic [ipv4lpm_pkg::LenW-1:0]  len_q, len_d;
  ipv4lpm_pkg::token_t           tok_q, tok_d;
  logic                          exact;
  logic                          covers;
  logic [ipv4lpm_pkg::AddrW-1:0] mask;

  assign mask   = ipv4lpm_pkg::len_mask(len_q);
  assign exact  = valid_i && (base_q == cmd_i.addr) && (len_q == cmd_i.len);
  assign covers = valid_i && ((base_q & mask) == (cmd_i.addr & mask));

  always_comb begin
    tok_d  = tok_i;
    base_d = base_q;
    len_d  = len_q;
    if (tok_i.active) begin
      case (tok_i.mode)
        ipv4lpm_pkg::MODE_SEARCH: begin
          case (cmd_i.op)
            ipv4lpm_pkg::ACT_ADD: begin
              if (exact) begin
                tok_d.mode = ipv4lpm_pkg::MODE_DONE;
              end else if (!valid_i || (len_q < cmd_i.len)) begin
                if (cmd_i.full) begin
                  tok_d.mode   = ipv4lpm_pkg::MODE_DONE;
                  tok_d.status = ipv4lpm_pkg::ST_FULL;
                end else begin
                  // insert here, push the old entry down the row
                  base_d           = cmd_i.addr;
                  len_d            = cmd_i.len;
                  tok_d.inc        = 1'b1;
                  tok_d.carry_base = base_q;
                  tok_d.carry_len  = len_q;
                  tok_d.mode       = valid_i ? ipv4lpm_pkg::MODE_SHIFT
                                             : ipv4lpm_pkg::MODE_DONE;
                end
              end
            end
            ipv4lpm_pkg::ACT_DEL: begin
              if (!valid_i) begin
                tok_d.mode   = ipv4lpm_pkg::MODE_DONE;
                tok_d.status = ipv4lpm_pkg::ST_NOT_FOUND;
              end else if (exact) begin
                base_d     = nb_base_i;
                len_d      = nb_len_i;
                tok_d.dec  = 1'b1;
                tok_d.mode = ipv4lpm_pkg::MODE_PULL;
              end
            end
            ipv4lpm_pkg::ACT_LOOKUP: begin
              if (!valid_i) begin
                tok_d.mode = ipv4lpm_pkg::MODE_DONE;
              end else if (covers) begin
                tok_d.mode    = ipv4lpm_pkg::MODE_DONE;
                tok_d.matched = 1'b1;
                tok_d.mlen    = len_q;
              end
            end
            default: tok_d.mode = ipv4lpm_pkg::MODE_DONE;
          endcase
        end
        ipv4lpm_pkg::MODE_SHIFT: begin
          base_d           = tok_i.carry_base;
          len_d            = tok_i.carry_len;
          tok_d.carry_base = base_q;
          tok_d.carry_len  = len_q;
          if (!valid_i) tok_d.mode = ipv4lpm_pkg::MODE_DONE;
        end
        ipv4lpm_pkg::MODE_PULL: begin
          if (valid_i) begin
            base_d = nb_base_i;
            len_d  = nb_len_i;
          end else begin
            tok_d.mode = ipv4lpm_pkg::MODE_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    len_q  <= len_d;
  end

  assign tok_o  = tok_q;
  assign base_o = base_q;
  assign len_o  = len_q;

endmodule
